// ===== rtl/jvpt_pkg.sv =====
// shared types and constants for the joint velocity pid torque block
// no dependencies; imported by every module of the block
package jvpt_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_KP        = 3'd0;
    localparam logic [2:0] CFG_KI        = 3'd1;
    localparam logic [2:0] CFG_KD        = 3'd2;
    localparam logic [2:0] CFG_MAX_TQ    = 3'd3;
    localparam logic [2:0] CFG_MAX_STEP  = 3'd4;
    localparam logic [2:0] CFG_MAX_GOAL  = 3'd5;
    localparam logic [2:0] CFG_CLAMP_EN  = 3'd6;

    // register values after reset
    localparam logic [15:0] KP_RESET       = 16'd40960;
    localparam logic [15:0] KI_RESET       = 16'd205;
    localparam logic [15:0] KD_RESET       = 16'd41;
    localparam logic [14:0] MAX_TQ_RESET   = 15'd22272;
    localparam logic [14:0] MAX_STEP_RESET = 15'd256;
    localparam logic [14:0] MAX_GOAL_RESET = 15'd8909;
    localparam logic        CLAMP_EN_RESET = 1'b1;

    // integral saturation bounds
    localparam logic signed [31:0] INTEG_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] INTEG_MIN = 32'sh8000_0000;

    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
        logic [14:0] max_torque;
        logic [14:0] max_step;
        logic [14:0] max_goal;
        logic        clamp_en;
    } cfg_t;

    // per-request bookkeeping that rides along the arithmetic pipeline
    typedef struct packed {
        logic [2:0]          joint;
        logic signed [15:0]  last;
        logic                ok;
        logic                close;
    } tag_t;

endpackage

// ===== rtl/jvpt_store.sv =====
// error history ring and integral memories with a clearing sweep after reset
// depends on jvpt_pkg
module jvpt_store
    import jvpt_pkg::*;
#(
    parameter int JOINTS = 7,
    parameter int WINDOW = 100,
    localparam int DEPTH = JOINTS * WINDOW,
    localparam int HA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int JA_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    output logic                   busy,
    input  logic                   rd_en,
    input  logic [HA_W-1:0]        hist_rd_addr,
    input  logic [JA_W-1:0]        int_rd_addr,
    output logic signed [16:0]     hist_rd_data,
    output logic signed [31:0]     int_rd_data,
    input  logic                   wr_en,
    input  logic [HA_W-1:0]        hist_wr_addr,
    input  logic signed [16:0]     hist_wr_data,
    input  logic [JA_W-1:0]        int_wr_addr,
    input  logic signed [31:0]     int_wr_data
);

    logic signed [16:0] hist_mem [DEPTH];
    logic signed [31:0] int_mem [JOINTS];

    logic              busy_reg;
    logic [HA_W-1:0]   cnt_reg;
    logic signed [16:0] hist_rd_reg;
    logic signed [31:0] int_rd_reg;

    assign busy         = busy_reg;
    assign hist_rd_data = hist_rd_reg;
    assign int_rd_data  = int_rd_reg;

    // sweep counter, one entry per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            if (cnt_reg == HA_W'(DEPTH - 1)) begin
                busy_reg <= 1'b0;
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (busy_reg) begin
            hist_mem[cnt_reg] <= '0;
            if ({1'b0, cnt_reg} < (HA_W + 1)'(JOINTS)) begin
                int_mem[cnt_reg[JA_W-1:0]] <= '0;
            end
        end else if (wr_en) begin
            hist_mem[hist_wr_addr] <= hist_wr_data;
            int_mem[int_wr_addr]   <= int_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            hist_rd_reg <= hist_mem[hist_rd_addr];
            int_rd_reg  <= int_mem[int_rd_addr];
        end
    end

endmodule

// ===== rtl/jvpt_math.sv =====
// five-stage pid arithmetic: products, sum, rounding, scaling, clamp
// depends on jvpt_pkg
module jvpt_math
    import jvpt_pkg::*;
#(
    parameter int WINDOW = 100
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  cfg_t               cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [16:0] in_err,
    input  logic signed [31:0] in_integ,
    input  logic signed [17:0] in_diff,
    input  tag_t               in_tag,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] out_torque,
    output logic               out_clamped,
    output tag_t               out_tag
);

    localparam int W_BITS = $clog2(WINDOW + 1);
    localparam int KW_W   = 16 + W_BITS;
    localparam int P_W    = KW_W + 18;
    localparam int IP_W   = KW_W + 33;
    localparam int DP_W   = 35;
    localparam int SUM_W  = IP_W + 2;
    localparam int X_W    = SUM_W + 1;
    localparam int Y_W    = X_W - 17;
    localparam int YL_W   = 15 + W_BITS;
    localparam int K      = YL_W;
    localparam int PR_W   = 2 * K + 1;
    localparam longint HALF_DEN = longint'(WINDOW) * 32768;
    localparam longint MREC     = (longint'(1) << K) / WINDOW;

    // gains scaled by the window length
    logic [KW_W-1:0] kpw_reg, kiw_reg;

    logic [4:0] v_reg;
    logic [4:0] mv;
    logic       in_fire;

    logic signed [P_W-1:0]   c_p_reg;
    logic signed [IP_W-1:0]  c_i_reg;
    logic signed [DP_W-1:0]  c_d_reg;
    tag_t                    c_tag_reg;

    logic signed [SUM_W-1:0] d_sum_reg;
    tag_t                    d_tag_reg;

    logic signed [X_W-1:0]   e_x;
    logic [Y_W-1:0]          e_y;
    logic [YL_W-1:0]         e_yl_reg;
    logic                    e_big_reg, e_neg_reg;
    tag_t                    e_tag_reg;

    logic [PR_W-1:0]         f_prod_reg;
    logic [YL_W-1:0]         f_yl_reg;
    logic                    f_big_reg, f_neg_reg;
    tag_t                    f_tag_reg;

    logic [14:0]             g_q0;
    logic [YL_W-1:0]         g_r;
    logic [15:0]             g_q;
    logic                    g_clamp;
    logic [14:0]             g_mag;
    logic signed [15:0]      g_tq;
    logic signed [15:0]      g_tq_reg;
    logic                    g_clamp_reg;
    tag_t                    g_tag_reg;

    always_ff @(posedge aclk) begin
        kpw_reg <= KW_W'(cfg.kp) * KW_W'(WINDOW);
        kiw_reg <= KW_W'(cfg.ki) * KW_W'(WINDOW);
    end

    // stage handshake, last stage first
    always_comb begin
        mv[4] = v_reg[4] & out_ready;
        for (int k = 3; k >= 0; k--) begin
            mv[k] = v_reg[k] & (~v_reg[k+1] | mv[k+1]);
        end
    end

    assign in_ready  = ~v_reg[0] | mv[0];
    assign in_fire   = in_valid & in_ready;
    assign out_valid = v_reg[4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg[0] <= in_fire | (v_reg[0] & ~mv[0]);
            for (int k = 1; k < 5; k++) begin
                v_reg[k] <= mv[k-1] | (v_reg[k] & ~mv[k]);
            end
        end
    end

    // rounding: magnitude plus half the divisor, then drop 16 fraction bits
    always_comb begin
        if (d_sum_reg[SUM_W-1]) begin
            e_x = X_W'(HALF_DEN) - X_W'(d_sum_reg);
        end else begin
            e_x = X_W'(d_sum_reg) + X_W'(HALF_DEN);
        end
        e_y = e_x[X_W-2:16];
    end

    // quotient by the window via reciprocal, one correction step, then clamp
    always_comb begin
        g_q0    = f_prod_reg[K+14:K];
        g_r     = f_yl_reg - YL_W'(g_q0) * YL_W'(WINDOW);
        g_q     = {1'b0, g_q0} + 16'(g_r >= YL_W'(WINDOW));
        g_clamp = f_big_reg | (g_q > {1'b0, cfg.max_torque});
        g_mag   = g_clamp ? cfg.max_torque : g_q[14:0];
        g_tq    = f_neg_reg ? -$signed({1'b0, g_mag}) : $signed({1'b0, g_mag});
    end

    always_ff @(posedge aclk) begin
        if (in_fire) begin
            c_p_reg   <= P_W'($signed({1'b0, kpw_reg})) * P_W'(in_err);
            c_i_reg   <= IP_W'($signed({1'b0, kiw_reg})) * IP_W'(in_integ);
            c_d_reg   <= DP_W'($signed({1'b0, cfg.kd})) * DP_W'(in_diff);
            c_tag_reg <= in_tag;
        end
        if (mv[0]) begin
            d_sum_reg <= SUM_W'(c_p_reg) + SUM_W'(c_i_reg) + SUM_W'(c_d_reg);
            d_tag_reg <= c_tag_reg;
        end
        if (mv[1]) begin
            e_yl_reg  <= e_y[YL_W-1:0];
            e_big_reg <= e_y >= Y_W'(HALF_DEN);
            e_neg_reg <= d_sum_reg[SUM_W-1];
            e_tag_reg <= d_tag_reg;
        end
        if (mv[2]) begin
            f_prod_reg <= PR_W'(e_yl_reg) * PR_W'(MREC);
            f_yl_reg   <= e_yl_reg;
            f_big_reg  <= e_big_reg;
            f_neg_reg  <= e_neg_reg;
            f_tag_reg  <= e_tag_reg;
        end
        if (mv[3]) begin
            g_tq_reg    <= g_tq;
            g_clamp_reg <= g_clamp;
            g_tag_reg   <= f_tag_reg;
        end
    end

    assign out_torque  = g_tq_reg;
    assign out_clamped = g_clamp_reg;
    assign out_tag     = g_tag_reg;

endmodule

// ===== rtl/joint_velocity_pid_torque_top.sv =====
// top level: velocity pid torque per joint, memories, pipeline control, rate limit
// depends on jvpt_pkg, jvpt_store, jvpt_math
// a request leaves stage a only once stage b is empty (ring read, then write-back of the same entry);
//   after the highest joint the next request also waits for the saturation flag
// reset: clears control state, then sweeps all JOINTS*WINDOW entries (700) clearing memories
module joint_velocity_pid_torque_top
    import jvpt_pkg::*;
#(
    parameter int JOINTS = 7,
    parameter int WINDOW = 100
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    // request channel
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_joint_index,
    input  logic signed [15:0] s_goal_velocity,
    input  logic signed [15:0] s_measured_velocity,
    input  logic signed [15:0] s_last_commanded_torque,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_joint_number,
    output logic signed [15:0] m_torque_command,
    output logic               m_torque_was_clamped
);

    localparam int DEPTH = JOINTS * WINDOW;
    localparam int HA_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int JA_W  = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int PT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int AD_W  = HA_W + 5;

    // ------------------------------------------------------------------
    // configuration registers, always ready (to be written only while idle; the block does not enforce this)
    // ------------------------------------------------------------------
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.kp         <= KP_RESET;
            cfg_reg.ki         <= KI_RESET;
            cfg_reg.kd         <= KD_RESET;
            cfg_reg.max_torque <= MAX_TQ_RESET;
            cfg_reg.max_step   <= MAX_STEP_RESET;
            cfg_reg.max_goal   <= MAX_GOAL_RESET;
            cfg_reg.clamp_en   <= CLAMP_EN_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_KP:       cfg_reg.kp         <= cfg_data;
                CFG_KI:       cfg_reg.ki         <= cfg_data;
                CFG_KD:       cfg_reg.kd         <= cfg_data;
                CFG_MAX_TQ:   cfg_reg.max_torque <= cfg_data[14:0];
                CFG_MAX_STEP: cfg_reg.max_step   <= cfg_data[14:0];
                CFG_MAX_GOAL: cfg_reg.max_goal   <= cfg_data[14:0];
                CFG_CLAMP_EN: cfg_reg.clamp_en   <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // control state
    // ------------------------------------------------------------------
    logic [PT_W-1:0] ptr_reg;         // ring slot of the current control cycle
    logic            sat_last_reg;    // some joint clamped in the previous cycle
    logic            sat_this_reg;    // some joint clamped so far in this cycle
    logic            close_pend_reg;  // closing joint in flight, flag not yet known

    logic clear_busy;

    // ------------------------------------------------------------------
    // stage a: request register, ring address, velocity error
    // ------------------------------------------------------------------
    logic               a_v_reg;
    logic [2:0]         a_j_reg;
    logic signed [15:0] a_goal_reg, a_meas_reg, a_last_reg;

    logic [4:0]         a_j5;
    logic               a_ok, a_close;
    logic               a_goal_hi;
    logic signed [16:0] a_goal_eff;
    logic signed [16:0] a_err;
    logic [AD_W-1:0]    a_addr_w;
    logic [HA_W-1:0]    hist_rd_addr;
    logic [JA_W-1:0]    int_rd_addr;
    logic               a_move;

    // stage b: memory data back, integral update, write-back
    logic               b_v_reg;
    tag_t               b_tag_reg;
    logic signed [16:0] b_err_reg;
    logic [HA_W-1:0]    b_addr_reg;
    logic [JA_W-1:0]    b_ji_reg;

    logic signed [16:0] hist_rd_data;
    logic signed [31:0] int_rd_data;
    logic signed [32:0] integ_sum;
    logic signed [31:0] integ_sat, integ_new;
    logic signed [17:0] b_diff;
    logic               hist_we;
    logic               b_move;

    // arithmetic pipe
    logic               math_in_ready;
    logic               math_out_valid, math_out_ready;
    logic signed [15:0] g_torque;
    logic               g_clamped;
    tag_t               g_tag;
    logic               g_move;
    logic               close_done;

    // result register and rate limit
    logic               m_valid_reg;
    logic [2:0]         m_joint_reg;
    logic signed [15:0] m_torque_reg;
    logic               m_clamped_reg;

    logic signed [16:0] rl_delta, rl_step, rl_lim, rl_sum;
    logic signed [15:0] rl_res;

    always_comb begin
        a_j5       = {2'b00, a_j_reg};
        a_ok       = a_j5 < 5'(JOINTS);
        a_close    = a_ok && (a_j5 == 5'(JOINTS - 1));
        // goal clamped above only
        a_goal_hi  = cfg_reg.clamp_en && (a_goal_reg > $signed({1'b0, cfg_reg.max_goal}));
        a_goal_eff = a_goal_hi ? $signed({2'b00, cfg_reg.max_goal}) : 17'(a_goal_reg);
        a_err      = a_goal_eff - 17'(a_meas_reg);
        a_addr_w   = AD_W'(a_j_reg) * AD_W'(WINDOW) + AD_W'(ptr_reg);
        // out-of-range joints touch no state, park the read on entry zero
        hist_rd_addr = a_ok ? a_addr_w[HA_W-1:0] : '0;
        int_rd_addr  = a_ok ? a_j5[JA_W-1:0] : '0;
    end

    // stage a moves only into an empty stage b, so the ring read of this
    // request always lands after the write-back of the one before it;
    // requests behind a closing joint wait for its saturation result
    assign a_move  = a_v_reg && !b_v_reg && !close_pend_reg && !clear_busy;
    assign s_ready = !clear_busy && (!a_v_reg || a_move);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_v_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            a_v_reg <= 1'b1;
        end else if (a_move) begin
            a_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            a_j_reg    <= s_joint_index;
            a_goal_reg <= s_goal_velocity;
            a_meas_reg <= s_measured_velocity;
            a_last_reg <= s_last_commanded_torque;
        end
    end

    // ------------------------------------------------------------------
    // stage b
    // ------------------------------------------------------------------
    always_comb begin
        integ_sum = 33'(int_rd_data) + 33'(b_err_reg);
        if (integ_sum[32] != integ_sum[31]) begin
            integ_sat = integ_sum[32] ? INTEG_MIN : INTEG_MAX;
        end else begin
            integ_sat = integ_sum[31:0];
        end
        // integral frozen while the previous cycle saturated
        integ_new = sat_last_reg ? int_rd_data : integ_sat;
        b_diff    = 18'(b_err_reg) - 18'(hist_rd_data);
    end

    assign b_move  = b_v_reg && math_in_ready;
    assign hist_we = b_move && b_tag_reg.ok;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_v_reg <= 1'b0;
        end else if (a_move) begin
            b_v_reg <= 1'b1;
        end else if (b_move) begin
            b_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_move) begin
            b_tag_reg.joint <= a_j_reg;
            b_tag_reg.last  <= a_last_reg;
            b_tag_reg.ok    <= a_ok;
            b_tag_reg.close <= a_close;
            b_err_reg       <= a_err;
            b_addr_reg      <= hist_rd_addr;
            b_ji_reg        <= int_rd_addr;
        end
    end

    // ring slot advances once the closing joint has written its entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg <= '0;
        end else if (b_move && b_tag_reg.close) begin
            if (ptr_reg == PT_W'(WINDOW - 1)) begin
                ptr_reg <= '0;
            end else begin
                ptr_reg <= ptr_reg + 1'b1;
            end
        end
    end

    jvpt_store #(
        .JOINTS (JOINTS),
        .WINDOW (WINDOW)
    ) u_store (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .busy         (clear_busy),
        .rd_en        (a_move),
        .hist_rd_addr (hist_rd_addr),
        .int_rd_addr  (int_rd_addr),
        .hist_rd_data (hist_rd_data),
        .int_rd_data  (int_rd_data),
        .wr_en        (hist_we),
        .hist_wr_addr (b_addr_reg),
        .hist_wr_data (b_err_reg),
        .int_wr_addr  (b_ji_reg),
        .int_wr_data  (integ_new)
    );

    // ------------------------------------------------------------------
    // pid arithmetic, stages c through g
    // ------------------------------------------------------------------
    jvpt_math #(
        .WINDOW (WINDOW)
    ) u_math (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg_reg),
        .in_valid    (b_v_reg),
        .in_ready    (math_in_ready),
        .in_err      (b_err_reg),
        .in_integ    (integ_new),
        .in_diff     (b_diff),
        .in_tag      (b_tag_reg),
        .out_valid   (math_out_valid),
        .out_ready   (math_out_ready),
        .out_torque  (g_torque),
        .out_clamped (g_clamped),
        .out_tag     (g_tag)
    );

    assign math_out_ready = !m_valid_reg || m_ready;
    assign g_move         = math_out_valid && math_out_ready;
    assign close_done     = g_move && g_tag.ok && g_tag.close;

    // saturation flags follow the clamp results in request order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sat_last_reg   <= 1'b0;
            sat_this_reg   <= 1'b0;
            close_pend_reg <= 1'b0;
        end else begin
            if (g_move && g_tag.ok) begin
                if (g_tag.close) begin
                    sat_last_reg <= sat_this_reg | g_clamped;
                    sat_this_reg <= 1'b0;
                end else begin
                    sat_this_reg <= sat_this_reg | g_clamped;
                end
            end
            if (a_move && a_close) begin
                close_pend_reg <= 1'b1;
            end else if (close_done) begin
                close_pend_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // rate limit against the last command, result register
    // ------------------------------------------------------------------
    always_comb begin
        rl_delta = 17'(g_torque) - 17'(g_tag.last);
        rl_step  = $signed({2'b00, cfg_reg.max_step});
        if (rl_delta > rl_step) begin
            rl_lim = rl_step;
        end else if (rl_delta < -rl_step) begin
            rl_lim = -rl_step;
        end else begin
            rl_lim = rl_delta;
        end
        rl_sum = 17'(g_tag.last) + rl_lim;
        // out-of-range joint echoes the last command
        rl_res = g_tag.ok ? rl_sum[15:0] : g_tag.last;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (g_move) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (g_move) begin
            m_joint_reg   <= g_tag.joint;
            m_torque_reg  <= rl_res;
            m_clamped_reg <= g_tag.ok && g_clamped;
        end
    end

    assign m_valid              = m_valid_reg;
    assign m_joint_number       = m_joint_reg;
    assign m_torque_command     = m_torque_reg;
    assign m_torque_was_clamped = m_clamped_reg;

`ifndef SYNTHESIS
    // no request is taken while the memories are being cleared
    ap_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_busy |-> !s_ready)
        else $error("request accepted during memory clear");

    // a ring read never shares an edge with the write-back of the same stage pair
    ap_read_after_write: assert property (@(posedge aclk) disable iff (!aresetn)
        !(a_move && hist_we))
        else $error("ring read overlaps write-back");

    // ring slot stays inside the window
    ap_ptr_range: assert property (@(posedge aclk) disable iff (!aresetn)
        ptr_reg <= PT_W'(WINDOW - 1))
        else $error("history pointer out of range");

    // the freeze flag changes only when a closing joint leaves the pipe
    ap_sat_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (sat_last_reg != $past(sat_last_reg)) |-> $past(close_done))
        else $error("saturation flag changed outside cycle close");
`endif

endmodule
